// File: rtl/core/rba_pkg.sv
// types and constants shared by the replicated block allocator
`default_nettype none

package rba_pkg;

	localparam int CAP_W   = 9;
	localparam int CAP_MAX = 511;

	localparam logic CMD_ATTACH = 1'b0;
	localparam logic CMD_ALLOC  = 1'b1;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_ATTACH_FAIL = 2'd1;
	localparam logic [1:0] STATUS_NO_SPACE    = 2'd2;

	typedef struct packed {
		logic             cmd;
		logic [CAP_W-1:0] capacity;
	} rba_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  first_node;
		logic [7:0]  first_block;
		logic [2:0]  second_node;
		logic [7:0]  second_block;
		logic [11:0] free_total;
	} rba_rsp_t;

	typedef struct packed {
		logic [CAP_W-1:0] cap;
		logic [CAP_W-1:0] free;
	} node_ent_t;

	typedef struct packed {
		logic      found;
		node_ent_t ent;
	} rba_best_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ATTACH,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_WR_A,
		ST_WR_B
	} rba_state_t;

endpackage

`default_nettype wire

// File: rtl/core/replicated_block_allocator_top.sv
// replicated block allocator: sequencer, node table and shared most-free compare unit
//
// channel   direction  handshake          payload
// command   in         start, busy        req  (cmd, capacity)
// result    out        done (one cycle)   rsp  (status, nodes, blocks, free_total)
//
// attach: the ATTACH state sets done_d, and done is registered from it.
// allocate: two scans over the node table through one registered memory read port and one
// compare unit, then one write per copy (ST_WR_A, ST_WR_B); with no node free done comes
// after the first scan, with only one node free after the second scan.
// blocks in a node are handed out in order, so the lowest free block is capacity - free.
// reset clears the node count and free total; no clearing pass is needed.
// busy is high from accept until the cycle before done; results cannot be stalled.
`default_nettype none

module replicated_block_allocator_top #(
	parameter int MAX_NODES       = 8,
	parameter int BLOCKS_PER_NODE = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire rba_pkg::rba_req_t req,
	output logic                   done,
	output rba_pkg::rba_rsp_t      rsp
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int TW = $clog2(MAX_NODES * rba_pkg::CAP_MAX + 1);

	rba_pkg::rba_state_t state_q, state_d;

	logic [rba_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]             count_q;
	logic [TW-1:0]             total_q, total_d;
	logic [CW-1:0]             iss_q;
	logic                      vld_s1;
	logic [NW-1:0]             idx_s1;
	logic [NW-1:0]             a_idx_q;
	rba_pkg::node_ent_t        a_ent_q;
	rba_pkg::rba_rsp_t         rsp_q, rsp_d;
	logic                      done_q, done_d;

	logic                      mem_we, mem_re;
	logic [NW-1:0]             mem_waddr, mem_raddr;
	rba_pkg::node_ent_t        mem_wdata, mem_rdata;

	logic                      pick_clr, skip_en;
	rba_pkg::rba_best_t        best;
	logic [NW-1:0]             best_idx;

	logic                      accept, scan_done, attach_ok;

	assign accept    = start && (state_q == rba_pkg::ST_IDLE);
	assign busy      = (state_q != rba_pkg::ST_IDLE);
	assign scan_done = (iss_q == count_q) && !vld_s1;
	assign attach_ok = (count_q != CW'(MAX_NODES)) && (cap_q != '0)
		&& (32'(cap_q) <= 32'(BLOCKS_PER_NODE));

	rba_node_mem #(
		.DEPTH (MAX_NODES),
		.AW    (NW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rba_pick #(
		.NW (NW)
	) u_pick (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (pick_clr),
		.vld      (vld_s1),
		.idx      (idx_s1),
		.ent      (mem_rdata),
		.skip_en  (skip_en),
		.skip_idx (a_idx_q),
		.best     (best),
		.best_idx (best_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rba_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (req.cmd == rba_pkg::CMD_ATTACH) ? rba_pkg::ST_ATTACH
						: rba_pkg::ST_SCAN_A;
				end
			end
			rba_pkg::ST_ATTACH: state_d = rba_pkg::ST_IDLE;
			rba_pkg::ST_SCAN_A: begin
				if (scan_done) begin
					state_d = best.found ? rba_pkg::ST_SCAN_B : rba_pkg::ST_IDLE;
				end
			end
			rba_pkg::ST_SCAN_B: begin
				if (scan_done) begin
					state_d = best.found ? rba_pkg::ST_WR_A : rba_pkg::ST_IDLE;
				end
			end
			rba_pkg::ST_WR_A: state_d = rba_pkg::ST_WR_B;
			rba_pkg::ST_WR_B: state_d = rba_pkg::ST_IDLE;
			default:          state_d = rba_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = iss_q[NW-1:0];
		pick_clr  = 1'b0;
		skip_en   = 1'b0;
		done_d    = 1'b0;
		total_d   = total_q;
		rsp_d     = '0;
		unique case (state_q)
			rba_pkg::ST_IDLE: begin
				pick_clr = accept;
			end
			rba_pkg::ST_ATTACH: begin
				done_d = 1'b1;
				if (attach_ok) begin
					mem_we           = 1'b1;
					mem_waddr        = count_q[NW-1:0];
					mem_wdata.cap    = cap_q;
					mem_wdata.free   = cap_q;
					total_d          = total_q + TW'(cap_q);
					rsp_d.status     = rba_pkg::STATUS_OK;
					rsp_d.first_node = 3'(count_q);
				end else begin
					rsp_d.status = rba_pkg::STATUS_ATTACH_FAIL;
				end
			end
			rba_pkg::ST_SCAN_A: begin
				mem_re       = (iss_q != count_q);
				pick_clr     = scan_done;
				done_d       = scan_done && !best.found;
				rsp_d.status = rba_pkg::STATUS_NO_SPACE;
			end
			rba_pkg::ST_SCAN_B: begin
				mem_re       = (iss_q != count_q);
				skip_en      = 1'b1;
				done_d       = scan_done && !best.found;
				rsp_d.status = rba_pkg::STATUS_NO_SPACE;
			end
			rba_pkg::ST_WR_A: begin
				mem_we         = 1'b1;
				mem_waddr      = a_idx_q;
				mem_wdata.cap  = a_ent_q.cap;
				mem_wdata.free = a_ent_q.free - 1'b1;
			end
			rba_pkg::ST_WR_B: begin
				mem_we             = 1'b1;
				mem_waddr          = best_idx;
				mem_wdata.cap      = best.ent.cap;
				mem_wdata.free     = best.ent.free - 1'b1;
				done_d             = 1'b1;
				total_d            = total_q - TW'(2);
				rsp_d.status       = rba_pkg::STATUS_OK;
				rsp_d.first_node   = 3'(a_idx_q);
				rsp_d.first_block  = 8'(a_ent_q.cap - a_ent_q.free);
				rsp_d.second_node  = 3'(best_idx);
				rsp_d.second_block = 8'(best.ent.cap - best.ent.free);
			end
			default: begin
			end
		endcase
		rsp_d.free_total = 12'(total_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rba_pkg::ST_IDLE;
			count_q <= '0;
			total_q <= '0;
			iss_q   <= '0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			total_q <= total_d;
			done_q  <= done_d;
			vld_s1  <= mem_re;
			if (pick_clr) begin
				iss_q <= '0;
			end else if (mem_re) begin
				iss_q <= iss_q + 1'b1;
			end
			if ((state_q == rba_pkg::ST_ATTACH) && attach_ok) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= mem_raddr;
		if (accept) begin
			cap_q <= req.capacity;
		end
		if ((state_q == rba_pkg::ST_SCAN_A) && scan_done) begin
			a_idx_q <= best_idx;
			a_ent_q <= best.ent;
		end
		if (done_d) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != rba_pkg::ST_IDLE))
		else $error("result without a command in progress");

	a_distinct_nodes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rba_pkg::ST_WR_B) |-> (a_idx_q != best_idx))
		else $error("both copies on the same node");

	a_nodes_have_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rba_pkg::ST_WR_B) |-> (a_ent_q.free != '0) && (best.ent.free != '0))
		else $error("allocation from a full node");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_NODES))
		else $error("node count overflow");

endmodule

`default_nettype wire

// File: rtl/core/rba_node_mem.sv
// node table memory: capacity and free count per node, registered read
`default_nettype none

module rba_node_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire rba_pkg::node_ent_t wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output rba_pkg::node_ent_t     rdata
);

	rba_pkg::node_ent_t mem_q [DEPTH];
	rba_pkg::node_ent_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/rba_pick.sv
// shared compare unit: keeps the node with the most free blocks seen in a scan
`default_nettype none

module rba_pick #(
	parameter int NW = 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               clr,
	input  wire logic               vld,
	input  wire logic [NW-1:0]      idx,
	input  wire rba_pkg::node_ent_t ent,
	input  wire logic               skip_en,
	input  wire logic [NW-1:0]      skip_idx,
	output rba_pkg::rba_best_t      best,
	output logic [NW-1:0]           best_idx
);

	rba_pkg::rba_best_t best_q;
	logic [NW-1:0]      best_idx_q;
	logic               take;

	// strict greater keeps the earliest node on ties and rejects full nodes
	assign take = vld && !(skip_en && (idx == skip_idx)) && (ent.free > best_q.ent.free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (clr) begin
			best_q     <= '0;
			best_idx_q <= '0;
		end else if (take) begin
			best_q.found <= 1'b1;
			best_q.ent   <= ent;
			best_idx_q   <= idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

`default_nettype wire

// File: tb/sv/replicated_block_allocator_top_tb.sv
// self-checking testbench for the replicated block allocator: directed and random command streams
`default_nettype none

module replicated_block_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES       = 8;
	localparam int BLOCKS      = 256;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 40;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	rba_pkg::rba_req_t req;
	logic              done;
	rba_pkg::rba_rsp_t rsp;

	bit          tbl_valid [NODES];
	int unsigned tbl_cap   [NODES];
	int unsigned tbl_free  [NODES];
	bit          tbl_used  [NODES][BLOCKS];
	int unsigned tbl_count;

	rba_pkg::rba_rsp_t pending_rsp [$];
	rba_pkg::rba_rsp_t want;
	int                errors = 0;
	int                cycles = 0;

	replicated_block_allocator_top #(
		.MAX_NODES      (NODES),
		.BLOCKS_PER_NODE(BLOCKS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int most_free_node(int skip);
		int best;
		int unsigned best_free;
		best = NODES;
		best_free = 0;
		for (int n = 0; n < NODES; n++) begin
			if (n != skip && tbl_valid[n] && tbl_free[n] > best_free) begin
				best_free = tbl_free[n];
				best = n;
			end
		end
		return best;
	endfunction

	function automatic int lowest_free_block(int n);
		for (int b = 0; b < tbl_cap[n] && b < BLOCKS; b++)
			if (!tbl_used[n][b])
				return b;
		return 0;
	endfunction

	// applies one accepted item to the node table and returns the result it should give
	function automatic rba_pkg::rba_rsp_t update_node_table(rba_pkg::rba_req_t r);
		rba_pkg::rba_rsp_t o;
		int                a;
		int                b;
		int                blk;
		int unsigned       sum;
		o = '0;
		if (r.cmd == rba_pkg::CMD_ATTACH) begin
			if (tbl_count >= NODES || r.capacity == 0 || r.capacity > BLOCKS) begin
				o.status = rba_pkg::STATUS_ATTACH_FAIL;
			end else begin
				tbl_valid[tbl_count] = 1'b1;
				tbl_cap[tbl_count]   = 32'(r.capacity);
				tbl_free[tbl_count]  = 32'(r.capacity);
				for (int i = 0; i < BLOCKS; i++)
					tbl_used[tbl_count][i] = 1'b0;
				o.status     = rba_pkg::STATUS_OK;
				o.first_node = tbl_count[2:0];
				tbl_count++;
			end
		end else begin
			a = most_free_node(NODES);
			b = (a < NODES) ? most_free_node(a) : NODES;
			if (a >= NODES || b >= NODES) begin
				o.status = rba_pkg::STATUS_NO_SPACE;
			end else begin
				blk = lowest_free_block(a);
				tbl_used[a][blk] = 1'b1;
				tbl_free[a]--;
				o.first_node  = a[2:0];
				o.first_block = blk[7:0];
				blk = lowest_free_block(b);
				tbl_used[b][blk] = 1'b1;
				tbl_free[b]--;
				o.second_node  = b[2:0];
				o.second_block = blk[7:0];
				o.status       = rba_pkg::STATUS_OK;
			end
		end
		sum = 0;
		for (int n = 0; n < NODES; n++)
			if (tbl_valid[n])
				sum += tbl_free[n];
		o.free_total = sum[11:0];
		return o;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, int got, int exp);
		if (got !== exp)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch("result with no item pending");
			end else begin
				want = pending_rsp.pop_front();
				check_field("status", int'(rsp.status), int'(want.status));
				check_field("first_node", int'(rsp.first_node), int'(want.first_node));
				check_field("first_block", int'(rsp.first_block), int'(want.first_block));
				check_field("second_node", int'(rsp.second_node), int'(want.second_node));
				check_field("second_block", int'(rsp.second_block),
					int'(want.second_block));
				check_field("free_total", int'(rsp.free_total), int'(want.free_total));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(logic c, logic [rba_pkg::CAP_W-1:0] cap);
		rba_pkg::rba_req_t r;
		r.cmd = c;
		r.capacity = cap;
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		pending_rsp.push_back(update_node_table(r));
	endtask

	task automatic hold_off(int n);
		start <= 1'b0;
		req <= rba_pkg::rba_req_t'($urandom);
		repeat (n) @(posedge clk);
	endtask

	task automatic test_empty_table;
		send_item(rba_pkg::CMD_ALLOC, 9'd0);
		send_item(rba_pkg::CMD_ATTACH, 9'd0);
		send_item(rba_pkg::CMD_ATTACH, 9'd257);
		send_item(rba_pkg::CMD_ATTACH, 9'd511);
	endtask

	task automatic test_alloc_selection;
		send_item(rba_pkg::CMD_ATTACH, 9'd1);
		send_item(rba_pkg::CMD_ALLOC, 9'd511);
		send_item(rba_pkg::CMD_ATTACH, 9'd256);
		send_item(rba_pkg::CMD_ALLOC, 9'd0);
		send_item(rba_pkg::CMD_ALLOC, 9'd0);
		// equal free counts on two nodes: lower index first
		send_item(rba_pkg::CMD_ATTACH, 9'd255);
		send_item(rba_pkg::CMD_ALLOC, 9'd0);
		send_item(rba_pkg::CMD_ALLOC, 9'd0);
	endtask

	task automatic test_table_full;
		send_item(rba_pkg::CMD_ATTACH, 9'd200);
		send_item(rba_pkg::CMD_ATTACH, 9'd129);
		send_item(rba_pkg::CMD_ATTACH, 9'd64);
		send_item(rba_pkg::CMD_ATTACH, 9'd128);
		send_item(rba_pkg::CMD_ATTACH, 9'd256);
		send_item(rba_pkg::CMD_ATTACH, 9'd100);
		send_item(rba_pkg::CMD_ATTACH, 9'd0);
		send_item(rba_pkg::CMD_ALLOC, 9'd0);
		send_item(rba_pkg::CMD_ALLOC, 9'd0);
	endtask

	task automatic test_random_traffic(int count, int idle_pct);
		logic                      c;
		logic [rba_pkg::CAP_W-1:0] cap;
		for (int i = 0; i < count; i++) begin
			while ($urandom_range(99) < idle_pct)
				hold_off(1);
			c = ($urandom_range(99) < 60) ? rba_pkg::CMD_ALLOC : rba_pkg::CMD_ATTACH;
			if (c == rba_pkg::CMD_ATTACH && $urandom_range(1))
				cap = rba_pkg::CAP_W'($urandom_range(1, BLOCKS));
			else
				cap = rba_pkg::CAP_W'($urandom_range(rba_pkg::CAP_MAX));
			send_item(c, cap);
		end
	endtask

	initial begin
		tbl_count = 0;
		for (int n = 0; n < NODES; n++) begin
			tbl_valid[n] = 1'b0;
			tbl_cap[n]   = 0;
			tbl_free[n]  = 0;
		end
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_alloc_selection();
		test_table_full();
		test_random_traffic(420, 38);
		test_random_traffic(420, 64);
		test_random_traffic(410, 0);

		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
rtl/core/rba_pkg.sv
rtl/core/rba_node_mem.sv
rtl/core/rba_pick.sv
rtl/core/replicated_block_allocator_top.sv
tb/sv/replicated_block_allocator_top_tb.sv
